// ----- src/first_fit_aligned_range_allocator_unit_assert.svh -----
// assertion macros for the range allocator
`ifndef FIRST_FIT_ALIGNED_RANGE_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_ALIGNED_RANGE_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define FFAR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");
`define FFAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check violated");
`else
`define FFAR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FFAR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/ffar_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ffar_pkg;

  // command codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ARG    = 3'd1;
  localparam logic [2:0] ST_NO_FIT     = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

  // operations broadcast to the cell row
  typedef enum logic [2:0] {
    C_NOP  = 3'd0,
    C_WR   = 3'd1,
    C_INS  = 3'd2,
    C_DEL  = 3'd3,
    C_CLR  = 3'd4,
    C_PREP = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     alloc;   // token match mode: fit test, else exact used match
    logic     dfree;   // free flag of the written entry
    logic     dvalid;  // clear: entry 0 present
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- src/ffar_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffar_cell import ffar_pkg::*; #(
  parameter int IDX       = 0,
  parameter int PW        = 6,
  parameter int AW        = 32,
  parameter logic [AW-1:0] RST_LEN = '0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cell_cmd_t       cmd,
  input  wire logic [PW-1:0]   pos,
  input  wire logic [AW-1:0]   d_start,
  input  wire logic [AW-1:0]   d_len,
  input  wire logic [31:0]     q_len,
  input  wire logic [31:0]     q_off,
  input  wire logic [31:0]     q_mask,
  input  wire logic            l_valid,
  input  wire logic            l_free,
  input  wire logic [AW-1:0]   l_start,
  input  wire logic [AW-1:0]   l_len,
  input  wire logic            r_valid,
  input  wire logic            r_free,
  input  wire logic [AW-1:0]   r_start,
  input  wire logic [AW-1:0]   r_len,
  output logic                 valid,
  output logic                 free,
  output logic [AW-1:0]        start,
  output logic [AW-1:0]        len,
  input  wire logic            ti_v,
  input  wire logic            ti_hit,
  input  wire logic            ti_lfr,
  input  wire logic [AW-1:0]   ti_ls,
  input  wire logic [AW-1:0]   ti_ll,
  input  wire logic [PW-1:0]   ti_idx,
  input  wire logic [AW-1:0]   ti_fs,
  input  wire logic [AW-1:0]   ti_fl,
  input  wire logic [((AW > 32) ? AW : 32)+1:0] ti_fa,
  input  wire logic            ti_nd,
  input  wire logic            ti_nfr,
  input  wire logic [AW-1:0]   ti_nl,
  output logic                 to_v,
  output logic                 to_hit,
  output logic                 to_lfr,
  output logic [AW-1:0]        to_ls,
  output logic [AW-1:0]        to_ll,
  output logic [PW-1:0]        to_idx,
  output logic [AW-1:0]        to_fs,
  output logic [AW-1:0]        to_fl,
  output logic [((AW > 32) ? AW : 32)+1:0] to_fa,
  output logic                 to_nd,
  output logic                 to_nfr,
  output logic [AW-1:0]        to_nl
);

  localparam int DW = ((AW > 32) ? AW : 32) + 2;
  localparam logic [PW-1:0] ME = PW'(IDX);

  logic [DW-1:0] a_r;
  logic [DW-1:0] e_w;
  logic [DW-1:0] bend_w;
  logic          fit;
  logic          hit_here;

  always_comb begin
    e_w      = a_r + DW'(q_len);
    bend_w   = DW'(start) + DW'(len);
    fit      = (e_w <= bend_w);
    hit_here = valid && (cmd.alloc ? (free && fit)
                                   : (!free && (DW'(start) == DW'(q_off))
                                            && (DW'(len) == DW'(q_len))));
  end

  // entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= (IDX == 0) && (RST_LEN != '0);
      free  <= 1'b1;
      start <= '0;
      len   <= RST_LEN;
    end else begin
      case (cmd.op)
        C_WR: begin
          if (pos == ME) begin
            start <= d_start;
            len   <= d_len;
            free  <= cmd.dfree;
          end
        end
        C_INS: begin
          if (pos == ME) begin
            valid <= 1'b1;
            start <= d_start;
            len   <= d_len;
            free  <= cmd.dfree;
          end else if (ME > pos) begin
            valid <= l_valid;
            start <= l_start;
            len   <= l_len;
            free  <= l_free;
          end
        end
        C_DEL: begin
          if (ME >= pos) begin
            valid <= r_valid;
            start <= r_start;
            len   <= r_len;
            free  <= r_free;
          end
        end
        C_CLR: begin
          valid <= (IDX == 0) && cmd.dvalid;
          start <= d_start;
          len   <= d_len;
          free  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // aligned start of this entry for the pending allocate
  always_ff @(posedge clk) begin
    if (cmd.op == C_PREP) begin
      a_r <= (DW'(start) + DW'(q_mask)) & ~DW'(q_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      to_v <= 1'b0;
    end else begin
      to_v <= ti_v;
    end
  end

  // search token, one cell per cycle
  always_ff @(posedge clk) begin
    to_hit <= ti_hit;
    to_lfr <= ti_lfr;
    to_ls  <= ti_ls;
    to_ll  <= ti_ll;
    to_idx <= ti_idx;
    to_fs  <= ti_fs;
    to_fl  <= ti_fl;
    to_fa  <= ti_fa;
    to_nd  <= ti_nd;
    to_nfr <= ti_nfr;
    to_nl  <= ti_nl;
    if (ti_v) begin
      if (!ti_hit) begin
        if (hit_here) begin
          to_hit <= 1'b1;
          to_idx <= ME;
          to_fs  <= start;
          to_fl  <= len;
          to_fa  <= a_r;
        end else begin
          to_lfr <= valid && free;
          to_ls  <= start;
          to_ll  <= len;
        end
      end else if (!ti_nd) begin
        to_nd  <= 1'b1;
        to_nfr <= valid && free;
        to_nl  <= len;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/first_fit_aligned_range_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_aligned_range_allocator_unit_assert.svh"
// First-fit range allocator. The block table lives in a row of MAX_BLOCKS
// cells, entry i in cell i, kept in address order. Allocate and free launch a
// search token into cell 0 that moves one cell per cycle; the first matching
// cell marks it and the token also picks up the free state of the entries on
// either side. When the token leaves the last cell the controller applies the
// edit as up to three one-cycle row commands (write, insert with a shift
// towards the end, delete with a shift towards the start). A successful
// allocate or free passes through prep, the token walk and the edit steps to
// done; an allocate that finds no fit or hits table full, and a free that
// finds nothing, go from the walk straight to done. Clear goes to the edit
// state, a rejected command straight to done. One command is worked on at a
// time; a finished result waits in the rsp register while the next command
// is taken. The capacity register is written through cfg and is used by the
// next clear; after reset the table holds one free block of 65536 units
// (saturated to the address range). Status codes: ok, bad argument, no fit,
// table full, not found.
module first_fit_aligned_range_allocator_unit import ffar_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] length,
  input  wire logic [31:0] alignment,
  input  wire logic [31:0] offset,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [2:0]       status,
  output logic [31:0]      granted_offset,
  output logic [31:0]      granted_length
);

  localparam int N  = MAX_BLOCKS;
  localparam int AW = ADDR_BITS;
  localparam int PW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int DW = ((AW > 32) ? AW : 32) + 2;
  localparam logic [DW-1:0] LIMIT   = (DW'(1) << AW) - DW'(1);
  localparam logic [AW-1:0] RST_LEN = AW'((DW'(65536) > LIMIT) ? LIMIT : DW'(65536));

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_SCAN = 5'b00100,
    S_EDIT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t         state;
  logic [1:0]     step;
  logic [1:0]     op_r;
  logic [31:0]    qlen;
  logic [31:0]    qmask;
  logic [31:0]    qoff;
  logic [31:0]    capacity;
  logic [CW-1:0]  count;
  logic           launch;

  // search result
  logic           hit_r;
  logic [PW-1:0]  k_r;
  logic [AW-1:0]  fs_r;
  logic [AW-1:0]  fl_r;
  logic [DW-1:0]  fa_r;
  logic           lfr_r;
  logic [AW-1:0]  ls_r;
  logic [AW-1:0]  ll_r;
  logic           nfr_r;
  logic [AW-1:0]  nl_r;

  // pending result
  logic [2:0]     res_st;
  logic [31:0]    res_off;
  logic [31:0]    res_len;

  // row command
  cell_cmd_t      cmd;
  logic [PW-1:0]  pos;
  logic [AW-1:0]  d_start;
  logic [AW-1:0]  d_len;

  // neighbour links, padded with an empty entry at each end
  logic           v_x [0:N+1];
  logic           f_x [0:N+1];
  logic [AW-1:0]  s_x [0:N+1];
  logic [AW-1:0]  l_x [0:N+1];

  // token links, index 0 is the launch point
  logic           tk_v   [0:N];
  logic           tk_hit [0:N];
  logic           tk_lfr [0:N];
  logic [AW-1:0]  tk_ls  [0:N];
  logic [AW-1:0]  tk_ll  [0:N];
  logic [PW-1:0]  tk_idx [0:N];
  logic [AW-1:0]  tk_fs  [0:N];
  logic [AW-1:0]  tk_fl  [0:N];
  logic [DW-1:0]  tk_fa  [0:N];
  logic           tk_nd  [0:N];
  logic           tk_nfr [0:N];
  logic [AW-1:0]  tk_nl  [0:N];

  logic           bad;
  logic [DW-1:0]  cap_sat;
  logic           t_gap;
  logic           t_rem;
  logic [CW:0]    need;
  logic [DW-1:0]  ee;
  logic [DW-1:0]  bend;
  logic           gap;
  logic           rem;
  logic [AW-1:0]  nadd;

  assign v_x[0]   = 1'b0;
  assign f_x[0]   = 1'b0;
  assign s_x[0]   = '0;
  assign l_x[0]   = '0;
  assign v_x[N+1] = 1'b0;
  assign f_x[N+1] = 1'b0;
  assign s_x[N+1] = '0;
  assign l_x[N+1] = '0;

  assign tk_v[0]   = launch;
  assign tk_hit[0] = 1'b0;
  assign tk_lfr[0] = 1'b0;
  assign tk_ls[0]  = '0;
  assign tk_ll[0]  = '0;
  assign tk_idx[0] = '0;
  assign tk_fs[0]  = '0;
  assign tk_fl[0]  = '0;
  assign tk_fa[0]  = '0;
  assign tk_nd[0]  = 1'b0;
  assign tk_nfr[0] = 1'b0;
  assign tk_nl[0]  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ffar_cell #(
      .IDX     (i),
      .PW      (PW),
      .AW      (AW),
      .RST_LEN (RST_LEN)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .pos     (pos),
      .d_start (d_start),
      .d_len   (d_len),
      .q_len   (qlen),
      .q_off   (qoff),
      .q_mask  (qmask),
      .l_valid (v_x[i]),
      .l_free  (f_x[i]),
      .l_start (s_x[i]),
      .l_len   (l_x[i]),
      .r_valid (v_x[i+2]),
      .r_free  (f_x[i+2]),
      .r_start (s_x[i+2]),
      .r_len   (l_x[i+2]),
      .valid   (v_x[i+1]),
      .free    (f_x[i+1]),
      .start   (s_x[i+1]),
      .len     (l_x[i+1]),
      .ti_v    (tk_v[i]),
      .ti_hit  (tk_hit[i]),
      .ti_lfr  (tk_lfr[i]),
      .ti_ls   (tk_ls[i]),
      .ti_ll   (tk_ll[i]),
      .ti_idx  (tk_idx[i]),
      .ti_fs   (tk_fs[i]),
      .ti_fl   (tk_fl[i]),
      .ti_fa   (tk_fa[i]),
      .ti_nd   (tk_nd[i]),
      .ti_nfr  (tk_nfr[i]),
      .ti_nl   (tk_nl[i]),
      .to_v    (tk_v[i+1]),
      .to_hit  (tk_hit[i+1]),
      .to_lfr  (tk_lfr[i+1]),
      .to_ls   (tk_ls[i+1]),
      .to_ll   (tk_ll[i+1]),
      .to_idx  (tk_idx[i+1]),
      .to_fs   (tk_fs[i+1]),
      .to_fl   (tk_fl[i+1]),
      .to_fa   (tk_fa[i+1]),
      .to_nd   (tk_nd[i+1]),
      .to_nfr  (tk_nfr[i+1]),
      .to_nl   (tk_nl[i+1])
    );
  end

  // configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    // argument check on the incoming command
    bad = (operation != OP_ALLOC) && (operation != OP_FREE) && (operation != OP_CLEAR);
    if ((operation != OP_CLEAR) && (length == '0)) begin
      bad = 1'b1;
    end
    if ((operation == OP_ALLOC)
        && ((alignment == '0) || ((alignment & (alignment - 32'd1)) != '0))) begin
      bad = 1'b1;
    end

    cap_sat = (DW'(capacity) > LIMIT) ? LIMIT : DW'(capacity);

    // split needs, seen as the token leaves the row
    t_gap = (tk_fa[N] != DW'(tk_fs[N]));
    t_rem = ((tk_fa[N] + DW'(qlen)) != (DW'(tk_fs[N]) + DW'(tk_fl[N])));
    need  = (CW+1)'(count) + (CW+1)'(t_gap) + (CW+1)'(t_rem);

    // edit values from the captured search result
    ee   = fa_r + DW'(qlen);
    bend = DW'(fs_r) + DW'(fl_r);
    gap  = (fa_r != DW'(fs_r));
    rem  = (ee != bend);
    nadd = nfr_r ? nl_r : '0;
  end

  // row command for the current state and edit step
  always_comb begin
    cmd.op     = C_NOP;
    cmd.alloc  = (op_r == OP_ALLOC);
    cmd.dfree  = 1'b1;
    cmd.dvalid = 1'b0;
    pos        = k_r;
    d_start    = '0;
    d_len      = '0;
    case (state)
      S_PREP: begin
        cmd.op = C_PREP;
      end
      S_EDIT: begin
        if (op_r == OP_CLEAR) begin
          cmd.op     = C_CLR;
          cmd.dvalid = (cap_sat != '0);
          d_len      = AW'(cap_sat);
        end else if (op_r == OP_ALLOC) begin
          case (step)
            2'd0: begin
              // trailing free remainder goes behind the found entry
              if (rem) begin
                cmd.op  = C_INS;
                pos     = k_r + PW'(1);
                d_start = AW'(ee);
                d_len   = AW'(bend - ee);
              end
            end
            2'd1: begin
              cmd.op    = C_WR;
              cmd.dfree = 1'b0;
              d_start   = AW'(fa_r);
              d_len     = AW'(qlen);
            end
            2'd2: begin
              // leading alignment gap goes in front
              if (gap) begin
                cmd.op  = C_INS;
                d_start = fs_r;
                d_len   = AW'(fa_r - DW'(fs_r));
              end
            end
            default: ;
          endcase
        end else begin
          case (step)
            2'd0: begin
              cmd.op = C_WR;
              if (lfr_r) begin
                pos     = k_r - PW'(1);
                d_start = ls_r;
                d_len   = ll_r + fl_r + nadd;
              end else begin
                d_start = fs_r;
                d_len   = fl_r + nadd;
              end
            end
            2'd1: begin
              if (nfr_r) begin
                cmd.op = C_DEL;
                pos    = k_r + PW'(1);
              end
            end
            2'd2: begin
              if (lfr_r) begin
                cmd.op = C_DEL;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      count     <= CW'(1);
      launch    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      launch <= (state == S_PREP);
      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            step <= '0;
            if (bad) begin
              state <= S_DONE;
            end else if (operation == OP_CLEAR) begin
              state <= S_EDIT;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (tk_v[N]) begin
            if (!tk_hit[N]) begin
              state <= S_DONE;
            end else if ((op_r == OP_ALLOC) && (need > (CW+1)'(N))) begin
              state <= S_DONE;
            end else begin
              state <= S_EDIT;
              if (op_r == OP_ALLOC) begin
                count <= CW'(need);
              end else begin
                count <= count - CW'(tk_lfr[N]) - CW'(tk_nd[N] && tk_nfr[N]);
              end
            end
          end
        end
        S_EDIT: begin
          step <= step + 2'd1;
          if (op_r == OP_CLEAR) begin
            count <= (cap_sat != '0) ? CW'(1) : '0;
            state <= S_DONE;
          end else if (step == 2'd2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // command and search payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && cmd_valid) begin
      op_r    <= operation;
      qlen    <= length;
      qmask   <= alignment - 32'd1;
      qoff    <= offset;
      res_st  <= bad ? ST_BAD_ARG : ST_OK;
      res_off <= '0;
      res_len <= '0;
    end
    if ((state == S_SCAN) && tk_v[N]) begin
      hit_r <= tk_hit[N];
      k_r   <= tk_idx[N];
      fs_r  <= tk_fs[N];
      fl_r  <= tk_fl[N];
      fa_r  <= tk_fa[N];
      lfr_r <= tk_lfr[N];
      ls_r  <= tk_ls[N];
      ll_r  <= tk_ll[N];
      nfr_r <= tk_nd[N] && tk_nfr[N];
      nl_r  <= tk_nl[N];
      if (!tk_hit[N]) begin
        res_st <= (op_r == OP_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
      end else if ((op_r == OP_ALLOC) && (need > (CW+1)'(N))) begin
        res_st <= ST_TABLE_FULL;
      end else if (op_r == OP_ALLOC) begin
        res_off <= tk_fa[N][31:0];
        res_len <= qlen;
      end
    end
    if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
      status         <= res_st;
      granted_offset <= res_off;
      granted_length <= res_len;
    end
  end

  `FFAR_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(N))
  `FFAR_ASSERT_IMPLY(a_token_in_scan, clk, rst, tk_v[N], state == S_SCAN)
  `FFAR_ASSERT_IMPLY(a_edit_after_hit, clk, rst, (state == S_EDIT) && (op_r != OP_CLEAR), hit_r)
  `FFAR_ASSERT_NEXT(a_prep_launch, clk, rst, state == S_PREP, launch && (state == S_SCAN))

endmodule
`default_nettype wire

// ----- test/range_allocator_checker.sv -----
`timescale 1ns / 1ps
module range_allocator_checker import ffar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        cmd_valid,
  input  logic        cmd_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] length,
  input  logic [31:0] alignment,
  input  logic [31:0] offset,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [2:0]  status,
  input  logic [31:0] granted_offset,
  input  logic [31:0] granted_length,
  output int          mismatch_count,
  output int          pending_count
);

  localparam int NBLK = 64;

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] goff;
    logic [31:0] glen;
  } grant_t;

  grant_t      pending_grants[$];
  logic [63:0] cap_reg;
  logic [63:0] tbl_start[NBLK];
  logic [63:0] tbl_len[NBLK];
  logic        tbl_free[NBLK];
  int          tbl_n;

  assign pending_count = pending_grants.size();

  function automatic void rebuild_blocks();
    logic [63:0] c;
    c = cap_reg;
    for (int k = 0; k < NBLK; k++) begin
      tbl_start[k] = 0; tbl_len[k] = 0; tbl_free[k] = 0;
    end
    tbl_n = 0;
    if (c != 0) begin
      tbl_len[0] = c; tbl_free[0] = 1; tbl_n = 1;
    end
  endfunction

  function automatic void drop_block(int p);
    for (int k = p; k + 1 < tbl_n; k++) begin
      tbl_start[k] = tbl_start[k+1]; tbl_len[k] = tbl_len[k+1];
      tbl_free[k] = tbl_free[k+1];
    end
    tbl_n--;
  endfunction

  function automatic void add_block(int p, logic [63:0] s, logic [63:0] l, logic f);
    for (int k = tbl_n; k > p; k--) begin
      tbl_start[k] = tbl_start[k-1]; tbl_len[k] = tbl_len[k-1];
      tbl_free[k] = tbl_free[k-1];
    end
    tbl_start[p] = s; tbl_len[p] = l; tbl_free[p] = f;
    tbl_n++;
  endfunction

  function automatic grant_t place_range(logic [63:0] len, logic [63:0] al);
    grant_t g;
    logic [63:0] s, bend, a, e;
    int extra;
    g = '0;
    if (len == 0 || al == 0 || (al & (al - 1)) != 0) begin
      g.st = ST_BAD_ARG;
      return g;
    end
    for (int i = 0; i < tbl_n; i++) begin
      if (!tbl_free[i]) continue;
      s = tbl_start[i];
      bend = s + tbl_len[i];
      a = (s + al - 1) & ~(al - 1);
      e = a + len;
      if (e > bend || e > 64'h1_0000_0000) continue;
      extra = (a > s) + (e < bend);
      if (tbl_n + extra > NBLK) begin
        g.st = ST_TABLE_FULL;
        return g;
      end
      tbl_start[i] = a; tbl_len[i] = len; tbl_free[i] = 0;
      if (e < bend) add_block(i + 1, e, bend - e, 1);
      if (a > s) add_block(i, s, a - s, 1);
      g.st = ST_OK; g.goff = a[31:0]; g.glen = len[31:0];
      return g;
    end
    g.st = ST_NO_FIT;
    return g;
  endfunction

  function automatic logic [2:0] release_range(logic [63:0] off, logic [63:0] len);
    if (len == 0) return ST_BAD_ARG;
    for (int i = 0; i < tbl_n; i++) begin
      if (tbl_start[i] != off || tbl_len[i] != len || tbl_free[i]) continue;
      tbl_free[i] = 1;
      if (i > 0 && tbl_free[i-1]) begin
        tbl_len[i-1] += tbl_len[i];
        drop_block(i);
        i--;
      end
      if (i + 1 < tbl_n && tbl_free[i+1]) begin
        tbl_len[i] += tbl_len[i+1];
        drop_block(i + 1);
      end
      return ST_OK;
    end
    return ST_NOT_FOUND;
  endfunction

  always @(posedge clk) begin
    grant_t g, want;
    if (rst) begin
      cap_reg = 64'd65536;
      rebuild_blocks();
      pending_grants.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = {32'd0, cfg_data};
      if (cmd_valid && cmd_ready) begin
        g = '0;
        case (operation)
          OP_ALLOC: g = place_range({32'd0, length}, {32'd0, alignment});
          OP_FREE:  g.st = release_range({32'd0, offset}, {32'd0, length});
          OP_CLEAR: begin
            rebuild_blocks();
            g.st = ST_OK;
          end
          default:  g.st = ST_BAD_ARG;
        endcase
        pending_grants.insert(pending_grants.size(), g);
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_grants.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected response, status %0d", status);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = pending_grants.pop_front();
          if (want.st != status || want.goff != granted_offset
              || want.glen != granted_length) begin
            if (mismatch_count < 10)
              $display("response mismatch: exp %0d/%h/%h got %0d/%h/%h",
                       want.st, want.goff, want.glen,
                       status, granted_offset, granted_length);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench import ffar_pkg::*;;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 0;
  logic        cmd_valid = 0;
  logic        cmd_ready;
  logic [1:0]  operation = OP_CLEAR;
  logic [31:0] length = 0;
  logic [31:0] alignment = 0;
  logic [31:0] offset = 0;
  logic        rsp_valid;
  logic        rsp_ready = 0;
  logic [2:0]  status;
  logic [31:0] granted_offset;
  logic [31:0] granted_length;

  int mismatch_count, pending_count;
  int unsigned cycle_count = 0;
  bit          calm_mode = 0;   // long stretch without gaps on either side

  // record of blocks we own, so frees mostly hit real allocations
  logic [31:0] held_off[$];
  logic [31:0] held_len[$];

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int MAX_BLOCKS_WAIT = 80;

  first_fit_aligned_range_allocator_unit i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .cmd_valid, .cmd_ready,
    .operation, .length, .alignment, .offset, .rsp_valid, .rsp_ready,
    .status, .granted_offset, .granted_length
  );

  range_allocator_checker i_checker (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .cmd_valid, .cmd_ready,
    .operation, .length, .alignment, .offset, .rsp_valid, .rsp_ready,
    .status, .granted_offset, .granted_length,
    .mismatch_count, .pending_count
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls at random, unless in the calm stretch
  always @(negedge clk) begin
    if (rst) rsp_ready <= 0;
    else rsp_ready <= calm_mode || ($urandom_range(99) >= 35);
  end

  // grants are remembered from the output side for later frees
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready && status == ST_OK && granted_length != 0) begin
      held_off.insert(held_off.size(), granted_offset);
      held_len.insert(held_len.size(), granted_length);
    end
  end

  task automatic send_command(logic [1:0] op, logic [31:0] len, logic [31:0] al,
                              logic [31:0] off);
    @(negedge clk);
    while (!calm_mode && $urandom_range(99) < 35) @(negedge clk);
    cmd_valid <= 1;
    operation <= op;
    length    <= len;
    alignment <= al;
    offset    <= off;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
    cmd_valid <= 0;
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
    repeat (MAX_BLOCKS_WAIT) @(negedge clk);
  endtask

  task automatic write_capacity(logic [31:0] v);
    wait_drained();
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    held_off.delete();
    held_len.delete();
    send_command(OP_CLEAR, 0, 0, 0);
  endtask

  function automatic logic [31:0] random_align();
    int sh;
    sh = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6);
    return 32'd1 << sh;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom();
    return w >> $urandom_range(31);
  endfunction

  task automatic random_item(logic [31:0] cap);
    int r, k;
    logic [31:0] len;
    r = $urandom_range(99);
    if (r < 50) begin
      // mostly sizes that fit; small chunks build up many table entries
      len = ($urandom_range(3) == 0) ? random_word()
          : $urandom_range(1, (cap > 4096 || cap == 0) ? 4096 : cap);
      send_command(OP_ALLOC, len, random_align(), $urandom());
    end else if (r < 85 && held_off.size() != 0) begin
      k = $urandom_range(held_off.size() - 1);
      send_command(OP_FREE, held_len[k], $urandom(), held_off[k]);
      held_off.delete(k);
      held_len.delete(k);
    end else if (r < 92) begin
      // noise: frees that miss or carry a zero length
      send_command(OP_FREE, random_word(), $urandom(), random_word());
    end else if (r < 96) begin
      send_command(OP_ALLOC, $urandom_range(1) ? 0 : random_word(), $urandom(), 0);
    end else if (r < 98) begin
      send_command(OP_RSVD, $urandom(), $urandom(), $urandom());
    end else begin
      held_off.delete();
      held_len.delete();
      send_command(OP_CLEAR, $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    logic [31:0] caps[5];
    caps = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd3000};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes and special cases on the reset table
    send_command(OP_ALLOC, 0, 1, 0);                 // zero length
    send_command(OP_ALLOC, 16, 0, 0);                // zero alignment
    send_command(OP_ALLOC, 16, 6, 0);                // not a power of two
    send_command(OP_ALLOC, 32'hFFFF_FFFF, 1, 0);     // no fit
    send_command(OP_ALLOC, 10, 1, 0);
    send_command(OP_ALLOC, 5, 32'h8000_0000, 0);     // huge alignment, no fit
    send_command(OP_ALLOC, 7, 256, 0);               // leading gap
    send_command(OP_FREE, 7, 0, 256);
    send_command(OP_FREE, 7, 0, 256);                // not found now
    send_command(OP_FREE, 0, 0, 0);                  // zero length free
    send_command(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_FREE, 10, 0, 0);
    // fill the table with one-unit slices on alignment 2 to hit table full
    for (int i = 0; i < 34; i++) send_command(OP_ALLOC, 1, 2, 0);
    send_command(OP_CLEAR, 0, 0, 0);

    write_capacity(32'hFFFF_FFFF);
    send_command(OP_ALLOC, 32'hFFFF_FFFF, 1, 0);     // whole saturated range
    send_command(OP_ALLOC, 1, 1, 0);
    send_command(OP_FREE, 32'hFFFF_FFFF, 0, 0);
    write_capacity(0);
    send_command(OP_ALLOC, 1, 1, 0);                 // empty table

    // random phases across capacity settings
    for (int ph = 0; ph < 10; ph++) begin
      write_capacity(ph < 5 ? caps[ph] : ($urandom() >> $urandom_range(31)));
      if (ph == 3) calm_mode = 1;
      for (int n = 0; n < 195; n++) begin
        random_item(i_checker.cap_reg[31:0]);
        if (n == 100 && ph == 6) wait_drained();    // sender holds until all answered
      end
      calm_mode = 0;
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- first_fit_aligned_range_allocator_unit.f -----
+incdir+src
src/ffar_pkg.sv
src/ffar_cell.sv
src/first_fit_aligned_range_allocator_unit.sv
test/range_allocator_checker.sv
test/testbench.sv
